[hw/rtl/swm_pkg.sv]
// Shared types and constants for the sliding window maximum filter.
// No dependencies.
`timescale 1ns / 1ps

package swm_pkg;

	localparam int MAX_WINDOW = 64;
	localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
	localparam int SAMPLE_W   = 32;

	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

	typedef struct packed {
		logic shift;
		logic scan;
	} cell_ctl_t;

endpackage

[hw/rtl/swm_cell.sv]
// One window cell: holds one sample and a partial maximum.
// Depends on swm_pkg.
`timescale 1ns / 1ps

module swm_cell (
	input  logic                                  clk,
	input  swm_pkg::cell_ctl_t                    ctl,
	input  logic                                  en,
	input  logic signed [swm_pkg::SAMPLE_W-1:0]   sample_in,
	input  logic signed [swm_pkg::SAMPLE_W-1:0]   acc_in,
	output logic signed [swm_pkg::SAMPLE_W-1:0]   sample_out,
	output logic signed [swm_pkg::SAMPLE_W-1:0]   acc_out
);
	import swm_pkg::*;

	logic signed [SAMPLE_W-1:0] sample_q;
	logic signed [SAMPLE_W-1:0] acc_q;

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			sample_q <= sample_in;
			acc_q    <= SAMPLE_MIN;
		end else if (ctl.scan) begin
			if (!en) begin
				acc_q <= SAMPLE_MIN;
			end else if (acc_in > sample_q) begin
				acc_q <= acc_in;
			end else begin
				acc_q <= sample_q;
			end
		end
	end

	assign sample_out = sample_q;
	assign acc_out    = acc_q;

endmodule

[hw/rtl/swm_ctrl.sv]
// Sequencer: window size register, sample count, scan counter, output valid.
// Depends on swm_pkg.
`timescale 1ns / 1ps

module swm_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          window_size_we,
	input  logic [swm_pkg::CNT_W-1:0]     window_size,
	input  logic                          in_valid,
	input  logic                          first,
	output logic                          in_stall,
	input  logic                          out_stall,
	output logic                          out_valid,
	output swm_pkg::cell_ctl_t            cell_ctl,
	output logic                          load,
	output logic [swm_pkg::CNT_W-1:0]     w_eff
);
	import swm_pkg::*;

	state_t            state_q, state_d;
	logic [CNT_W-1:0]  window_size_q;
	logic [CNT_W-1:0]  seen_q, seen_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic [CNT_W-1:0]  seen_inc, seen_next;
	logic              out_valid_q, out_valid_d;
	logic              out_free;

	always_comb begin
		if (window_size_q == '0) begin
			w_eff = CNT_W'(1);
		end else if (window_size_q > CNT_W'(MAX_WINDOW)) begin
			w_eff = CNT_W'(MAX_WINDOW);
		end else begin
			w_eff = window_size_q;
		end
	end

	assign seen_inc  = (first ? '0 : seen_q) + CNT_W'(1);
	assign seen_next = (seen_inc > w_eff) ? w_eff : seen_inc;
	assign out_free  = !out_valid_q || !out_stall;

	always_comb begin
		state_d        = state_q;
		seen_d         = seen_q;
		cnt_d          = cnt_q;
		cell_ctl.shift = 1'b0;
		cell_ctl.scan  = 1'b0;
		load           = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cell_ctl.shift = 1'b1;
					seen_d         = seen_next;
					if (seen_next == w_eff) begin
						state_d = ST_SCAN;
						cnt_d   = '0;
					end
				end
			end
			ST_SCAN: begin
				if (cnt_q != w_eff) begin
					cell_ctl.scan = 1'b1;
					cnt_d         = cnt_q + CNT_W'(1);
				end else if (out_free) begin
					load    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		out_valid_d = out_valid_q;
		if (load) begin
			out_valid_d = 1'b1;
		end else if (!out_stall) begin
			out_valid_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q <= CNT_W'(1);
			seen_q        <= '0;
			cnt_q         <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (window_size_we) begin
				window_size_q <= window_size;
			end
			seen_q      <= seen_d;
			cnt_q       <= cnt_d;
			out_valid_q <= out_valid_d;
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

[hw/rtl/sliding_window_maximum.sv]
// Top level of the sliding window maximum filter: cell chain plus output register.
// Depends on swm_pkg, swm_cell, swm_ctrl.
//
//   channel   direction   handshake              payload
//   config    in          window_size_we         window_size[6:0]
//   input     in          in_valid / in_stall    sample[31:0], first
//   output    out         out_valid / out_stall  window_max[31:0]
//
// A sample that completes a window (w = effective window) is shifted in, then takes w
// partial-maximum steps toward cell 0, and then its result is loaded into the output register.
// A sample that gives no result is only shifted in.
// in_stall is high from the transfer of a result-giving sample until its result is loaded;
// a stalled output holds the chain at the end of the scan.
// Reset clears the control state and sets the window size to 1; samples are not cleared.
`timescale 1ns / 1ps

module sliding_window_maximum (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  window_size_we,
	input  logic [swm_pkg::CNT_W-1:0]             window_size,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [swm_pkg::SAMPLE_W-1:0]   sample,
	input  logic                                  first,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [swm_pkg::SAMPLE_W-1:0]   window_max
);
	import swm_pkg::*;

	cell_ctl_t                  cell_ctl;
	logic                       load;
	logic [CNT_W-1:0]           w_eff;
	logic signed [SAMPLE_W-1:0] smp [MAX_WINDOW];
	logic signed [SAMPLE_W-1:0] acc [MAX_WINDOW+1];
	logic signed [SAMPLE_W-1:0] window_max_q;

	swm_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.window_size_we (window_size_we),
		.window_size    (window_size),
		.in_valid       (in_valid),
		.first          (first),
		.in_stall       (in_stall),
		.out_stall      (out_stall),
		.out_valid      (out_valid),
		.cell_ctl       (cell_ctl),
		.load           (load),
		.w_eff          (w_eff)
	);

	assign acc[MAX_WINDOW] = SAMPLE_MIN;

	for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
		logic signed [SAMPLE_W-1:0] cell_in;
		if (i == 0) begin : g_head
			assign cell_in = sample;
		end else begin : g_body
			assign cell_in = smp[i-1];
		end
		swm_cell u_cell (
			.clk        (clk),
			.ctl        (cell_ctl),
			.en         (CNT_W'(i) < w_eff),
			.sample_in  (cell_in),
			.acc_in     (acc[i+1]),
			.sample_out (smp[i]),
			.acc_out    (acc[i])
		);
	end

	always_ff @(posedge clk) begin
		if (load) begin
			window_max_q <= acc[0];
		end
	end

	assign window_max = window_max_q;

`ifndef ASSERT_OFF
	a_scan_stalls_input : assert property (@(posedge clk) disable iff (!arst_n)
		cell_ctl.scan |-> in_stall)
		else $error("scan step while input side open");

	a_load_no_overwrite : assert property (@(posedge clk) disable iff (!arst_n)
		load |-> !(out_valid && out_stall))
		else $error("result loaded over a stalled result");

	a_one_at_a_time : assert property (@(posedge clk) disable iff (!arst_n)
		(cell_ctl.shift && in_stall) |-> 1'b0)
		else $error("sample shifted in while busy");

	a_load_after_scan : assert property (@(posedge clk) disable iff (!arst_n)
		load |-> !cell_ctl.scan && !cell_ctl.shift)
		else $error("load overlaps chain activity");
`endif

endmodule
